### rtl/ope_pkg.sv
// ----------------------------------------------------------------------------
// ope_pkg
// Shared widths, limits, register indexes and the stage bus type of the
// offset polynomial evaluator.
// ----------------------------------------------------------------------------
package ope_pkg;

  // Polynomial degree and coefficient register count
  localparam int MAX_DEGREE = 6;
  localparam int NUM_COEF   = 7;
  localparam int NUM_STEPS  = MAX_DEGREE + 1;

  // Datapath widths
  localparam int XW     = 32;  // Q16.16 sample, offset, coefficient
  localparam int DW     = 33;  // Q17.16 sample minus offset
  localparam int ACCW   = 48;  // Q32.16 accumulator
  localparam int DCW    = 35;  // k * coef_k
  localparam int PLW    = 65;  // low partial product, 32 x 33
  localparam int PHW    = 49;  // high partial product, 16 x 33
  localparam int QW     = 66;  // rounded magnitude before clamp
  localparam int SUMW   = 50;  // coefficient add
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd1;

  // Accumulator limits
  localparam logic signed [ACCW-1:0] ACC_MAX = {1'b0, {(ACCW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] ACC_MIN = {1'b1, {(ACCW-1){1'b0}}};
  localparam logic [ACCW-1:0] MAG_POS_LIM = {1'b0, {(ACCW-1){1'b1}}};
  localparam logic [ACCW-1:0] MAG_NEG_LIM = {1'b1, {(ACCW-1){1'b0}}};

  // Item state between Horner steps
  typedef struct packed {
    logic signed [ACCW-1:0] acc;
    logic signed [DW-1:0]   d;
    logic                   op;
    logic                   ovf;
  } step_bus_t;

endpackage

### rtl/ope_horner_step.sv
// ----------------------------------------------------------------------------
// ope_horner_step
// One Horner step, acc = sat(sat(round(acc * d)) + e), in four register
// stages: magnitudes, partial products, round and clamp, coefficient add.
// ----------------------------------------------------------------------------
module ope_horner_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ope_pkg::step_bus_t                in_bus_i,
  input  logic signed [ope_pkg::XW-1:0]     e_poly_i,
  input  logic signed [ope_pkg::DCW-1:0]    e_der_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ope_pkg::step_bus_t                out_bus_o
);
  import ope_pkg::*;

  // Stage valids and advance chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Stage 1: magnitudes of accumulator and d, product sign
  logic [ACCW-1:0] a_mag_d, a_mag_q;
  logic [DW-1:0]   b_mag_d, b_mag_q;
  logic            neg1_q, op1_q, ovf1_q;
  logic signed [DW-1:0] d1_q;

  assign a_mag_d = in_bus_i.acc[ACCW-1] ? ACCW'(-in_bus_i.acc) : ACCW'(in_bus_i.acc);
  assign b_mag_d = in_bus_i.d[DW-1] ? DW'(-in_bus_i.d) : DW'(in_bus_i.d);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      a_mag_q <= a_mag_d;
      b_mag_q <= b_mag_d;
      neg1_q  <= in_bus_i.acc[ACCW-1] ^ in_bus_i.d[DW-1];
      op1_q   <= in_bus_i.op;
      ovf1_q  <= in_bus_i.ovf;
      d1_q    <= in_bus_i.d;
    end
  end

  // Stage 2: partial products of the magnitudes
  logic [PLW-1:0] p_lo_q;
  logic [PHW-1:0] p_hi_q;
  logic           neg2_q, op2_q, ovf2_q;
  logic signed [DW-1:0] d2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      p_lo_q <= PLW'(a_mag_q[31:0]) * PLW'(b_mag_q);
      p_hi_q <= PHW'(a_mag_q[ACCW-1:32]) * PHW'(b_mag_q);
      neg2_q <= neg1_q;
      op2_q  <= op1_q;
      ovf2_q <= ovf1_q;
      d2_q   <= d1_q;
    end
  end

  // Stage 3: drop 16 fraction bits, round half away from zero, clamp
  logic [QW-1:0]   rnd, q;
  logic [ACCW-1:0] lim, qs_d, qs_q;
  logic            qov;
  logic            neg3_q, op3_q, ovf3_q;
  logic signed [DW-1:0] d3_q;

  always_comb begin
    rnd  = QW'(p_lo_q) + QW'(17'h08000);
    q    = QW'({p_hi_q, 16'b0}) + QW'(rnd[QW-1:16]);
    lim  = neg2_q ? MAG_NEG_LIM : MAG_POS_LIM;
    qov  = q > QW'(lim);
    qs_d = qov ? lim : q[ACCW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      qs_q   <= qs_d;
      neg3_q <= neg2_q;
      op3_q  <= op2_q;
      ovf3_q <= ovf2_q | qov;
      d3_q   <= d2_q;
    end
  end

  // Stage 4: apply sign, add coefficient, saturate
  logic signed [SUMW-1:0] e_ext, q_ext, sum;
  logic signed [ACCW-1:0] acc_d;
  logic                   sov;
  step_bus_t              out_q;

  always_comb begin
    e_ext = op3_q ? SUMW'(e_der_i) : SUMW'(e_poly_i);
    q_ext = $signed(SUMW'(qs_q));
    sum   = neg3_q ? (e_ext - q_ext) : (e_ext + q_ext);
    sov   = 1'b0;
    if (sum > SUMW'(ACC_MAX)) begin
      acc_d = ACC_MAX;
      sov   = 1'b1;
    end else if (sum < SUMW'(ACC_MIN)) begin
      acc_d = ACC_MIN;
      sov   = 1'b1;
    end else begin
      acc_d = sum[ACCW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      out_q.acc <= acc_d;
      out_q.d   <= d3_q;
      out_q.op  <= op3_q;
      out_q.ovf <= ovf3_q | sov;
    end
  end

  assign out_valid_o = v4_q;
  assign out_bus_o   = out_q;

`ifndef SYNTHESIS
  // Clamped magnitude never exceeds the negative limit
  a_qs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (qs_q <= MAG_NEG_LIM))
    else $error("rounded magnitude beyond limit");

  // A blocked stage 3 item stays put
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !adv4) |=> (v3_q && $stable(qs_q) && $stable(neg3_q)))
    else $error("stage 3 item lost while blocked");
`endif

endmodule

### rtl/offset_polynomial_eval_core.sv
// Each Horner step is its own four-stage pipeline slice after the entry register.
// Throughput: one beat per cycle unless the result stream holds m_axis_tready low.
// Stalls collapse bubbles stage by stage; while a result waits, input fills empty stages.
// Reset clears the offset and coefficient registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// offset_polynomial_eval_core
// Calibration polynomial evaluator: evaluates the polynomial in
// (sample - offset), or its derivative, by Horner's rule in Q32.16 with
// saturation and an overflow flag.
// ----------------------------------------------------------------------------
module offset_polynomial_eval_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ope_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ope_pkg::XW-1:0]               cfg_wdata_i,
  // Sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,   // [31:0] sample_x
  input  logic [0:0]                           s_axis_tuser,   // [0] opcode
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [47:0]                          m_axis_tdata,   // [47:0] calibrated_value
  output logic [0:0]                           m_axis_tuser    // [0] overflow
);
  import ope_pkg::*;

  // Configuration registers
  logic signed [XW-1:0]  x_offset_q;
  logic signed [XW-1:0]  coef_q  [NUM_COEF];
  logic signed [DCW-1:0] dcoef_q [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q <= '0;
      for (int c = 0; c < NUM_COEF; c++) begin
        coef_q[c]  <= '0;
        dcoef_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_X_OFFSET) x_offset_q <= $signed(cfg_wdata_i);
      for (int c = 0; c < NUM_COEF; c++) begin
        if (cfg_idx_i == CFG_COEF_BASE + CFG_IDX_W'(c)) begin
          coef_q[c]  <= $signed(cfg_wdata_i);
          dcoef_q[c] <= DCW'($signed(cfg_wdata_i)) * $signed(DCW'(c));
        end
      end
    end
  end

  // Entry stage: form d = sample - offset
  logic                 e0_v_q;
  logic signed [DW-1:0] e0_d_q;
  logic                 e0_op_q;
  logic                 rdy [NUM_STEPS+1];
  logic                 vld [NUM_STEPS+1];
  step_bus_t            bus [NUM_STEPS+1];

  assign s_axis_tready = !e0_v_q || rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      e0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      e0_d_q  <= DW'($signed(s_axis_tdata)) - DW'(x_offset_q);
      e0_op_q <= s_axis_tuser[0];
    end
  end

  // Horner steps start from a zero accumulator
  assign vld[0]     = e0_v_q;
  assign bus[0].acc = '0;
  assign bus[0].d   = e0_d_q;
  assign bus[0].op  = e0_op_q;
  assign bus[0].ovf = 1'b0;

  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
    logic signed [DCW-1:0] e_der;

    if (s == 0) begin : g_lead
      assign e_der = '0;
    end else begin : g_body
      assign e_der = dcoef_q[MAX_DEGREE - s + 1];
    end

    ope_horner_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[s]),
      .in_ready_o  (rdy[s]),
      .in_bus_i    (bus[s]),
      .e_poly_i    (coef_q[MAX_DEGREE - s]),
      .e_der_i     (e_der),
      .out_valid_o (vld[s+1]),
      .out_ready_i (rdy[s+1]),
      .out_bus_o   (bus[s+1])
    );
  end

  // Last stage register drives the result stream
  assign rdy[NUM_STEPS]  = m_axis_tready;
  assign m_axis_tvalid   = vld[NUM_STEPS];
  assign m_axis_tdata    = bus[NUM_STEPS].acc;
  assign m_axis_tuser[0] = bus[NUM_STEPS].ovf;

`ifndef SYNTHESIS
  // An empty output register lets the whole pipeline move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // An accepted beat lands in the entry stage
  a_entry_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> e0_v_q)
    else $error("accepted beat dropped at entry");
`endif

endmodule
